>>> hw/rtl/ldp_pkg.sv
// Shared types, constants and saturating helpers for the lens distortion projection.
// No dependencies; every other file but ldp_delay imports this package.
package ldp_pkg;

  typedef logic signed [63:0] q32_t;

  localparam q32_t Q32_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q32_t Q32_MIN = 64'sh8000_0000_0000_0000;
  localparam q32_t Q32_ONE = 64'sh0000_0001_0000_0000;

  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int MUL_LAT   = 4;

  typedef enum logic [2:0] {
    REG_FOCAL     = 3'd0,
    REG_PRINCIPAL = 3'd1,
    REG_SKEW      = 3'd2,
    REG_K1        = 3'd3,
    REG_K2        = 3'd4,
    REG_K3        = 3'd5,
    REG_P1        = 3'd6,
    REG_P2        = 3'd7
  } reg_idx_t;

  function automatic q32_t sat_add(input q32_t a, input q32_t b);
    q32_t s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      s = a[63] ? Q32_MIN : Q32_MAX;
    end
    return s;
  endfunction

  function automatic q32_t sign_mag_sat(input logic neg, input logic [63:0] mag);
    q32_t r;
    if (!neg) begin
      r = mag[63] ? Q32_MAX : q32_t'(mag);
    end else begin
      r = mag[63] ? Q32_MIN : q32_t'(~mag + 64'd1);
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(input q32_t v);
    logic [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/ldp_delay.sv
// Enable-gated shift line that keeps operands aligned with the pipeline.
// Depends on nothing; DEPTH must be at least 1.
module ldp_delay #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

>>> hw/rtl/ldp_div.sv
// Pipelined restoring divider: (num * 2^32) / den, one quotient bit per stage.
// Uses ldp_pkg for the sign/saturation helper and stage count.
module ldp_div import ldp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] num,
  input  logic [30:0]        den,
  output q32_t               quo
);

  logic [30:0] rem_r   [DIV_STEPS];
  logic [30:0] rem_nxt [DIV_STEPS];
  logic [63:0] q_r     [DIV_STEPS];
  logic [63:0] q_nxt   [DIV_STEPS];
  logic [31:0] m_r     [DIV_STEPS];
  logic [31:0] m_nxt   [DIV_STEPS];
  logic [30:0] den_r   [DIV_STEPS];
  logic [30:0] den_nxt [DIV_STEPS];
  logic        neg_r   [DIV_STEPS];
  logic        neg_nxt [DIV_STEPS];
  q32_t        quo_r;

  always_comb begin
    logic [31:0] mag0;
    logic [30:0] rem_p;
    logic [63:0] q_p;
    logic [31:0] m_p;
    logic [30:0] den_p;
    logic        neg_p;
    logic [31:0] trial;
    mag0 = num[31] ? (~num + 32'd1) : num;
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        rem_p = '0;
        q_p   = '0;
        m_p   = mag0;
        den_p = den;
        neg_p = num[31];
      end else begin
        rem_p = rem_r[s-1];
        q_p   = q_r[s-1];
        m_p   = m_r[s-1];
        den_p = den_r[s-1];
        neg_p = neg_r[s-1];
      end
      // dividend bits: magnitude first, then the 32 zero fraction bits
      trial = {rem_p, m_p[31]};
      if (trial >= {1'b0, den_p}) begin
        rem_nxt[s] = 31'(trial - {1'b0, den_p});
        q_nxt[s]   = {q_p[62:0], 1'b1};
      end else begin
        rem_nxt[s] = trial[30:0];
        q_nxt[s]   = {q_p[62:0], 1'b0};
      end
      m_nxt[s]   = {m_p[30:0], 1'b0};
      den_nxt[s] = den_p;
      neg_nxt[s] = neg_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
        m_r[s]   <= m_nxt[s];
        den_r[s] <= den_nxt[s];
        neg_r[s] <= neg_nxt[s];
      end
      quo_r <= sign_mag_sat(neg_r[DIV_STEPS-1], q_r[DIV_STEPS-1]);
    end
  end

  assign quo = quo_r;

endmodule

>>> hw/rtl/ldp_mul.sv
// Four-stage Q32.32 multiplier: rounds half away from zero and saturates.
// Uses ldp_pkg for the Q32.32 type and limits; 32x32 partial products only.
module ldp_mul import ldp_pkg::*; (
  input  logic clk,
  input  logic en,
  input  q32_t a,
  input  q32_t b,
  output q32_t p
);

  logic [63:0]  ua_r, ub_r;
  logic         neg1_r, neg2_r, neg3_r;
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] sum;
  logic         ovf_r;
  logic [63:0]  res_r;
  q32_t         p_r;

  assign sum = {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
             + {p11_r, 64'b0} + 128'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= a[63] ? (~a + 64'd1) : a;
      ub_r   <= b[63] ? (~b + 64'd1) : b;
      neg1_r <= a[63] ^ b[63];

      p00_r  <= 64'(ua_r[31:0])  * 64'(ub_r[31:0]);
      p01_r  <= 64'(ua_r[31:0])  * 64'(ub_r[63:32]);
      p10_r  <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      p11_r  <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      neg2_r <= neg1_r;

      ovf_r  <= |sum[127:96];
      res_r  <= sum[95:32];
      neg3_r <= neg2_r;

      if (ovf_r) begin
        p_r <= neg3_r ? Q32_MIN : Q32_MAX;
      end else begin
        p_r <= sign_mag_sat(neg3_r, res_r);
      end
    end
  end

  assign p = p_r;

endmodule

>>> hw/rtl/lens_distortion_projection.sv
// Brown-Conrady projection of camera-frame points to distorted pixels. Accepts one point per
// clock while the pipeline is not stalled and returns one pixel per point, in order, after the
// bit-per-stage depth divider, six chained four-stage multipliers and six register stages of
// saturating adds and output registers. Backpressure on the result side freezes the whole
// pipeline in place. Program the registers (64-bit APB, byte address 8*index) while no point
// is in flight.
// Depends on ldp_pkg, ldp_div, ldp_mul and ldp_delay.
module lens_distortion_projection import ldp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_camera_x,
  input  logic signed [31:0] in_camera_y,
  input  logic signed [31:0] in_camera_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_pixel_x,
  output logic signed [31:0] out_pixel_y,
  output logic               out_behind_camera
);

  localparam int PIPE_LAT = DIV_LAT + 6 * MUL_LAT + 6;

  // configuration registers
  logic [63:0] focal_r, principal_r;
  logic [31:0] skew_r, k1_r, k2_r, k3_r, p1_r, p2_r;
  reg_idx_t    reg_idx;

  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r     <= '0;
      principal_r <= '0;
      skew_r      <= '0;
      k1_r        <= '0;
      k2_r        <= '0;
      k3_r        <= '0;
      p1_r        <= '0;
      p2_r        <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_FOCAL:     focal_r     <= pwdata;
        REG_PRINCIPAL: principal_r <= pwdata;
        REG_SKEW:      skew_r      <= pwdata[31:0];
        REG_K1:        k1_r        <= pwdata[31:0];
        REG_K2:        k2_r        <= pwdata[31:0];
        REG_K3:        k3_r        <= pwdata[31:0];
        REG_P1:        p1_r        <= pwdata[31:0];
        REG_P2:        p2_r        <= pwdata[31:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FOCAL:     prdata = focal_r;
      REG_PRINCIPAL: prdata = principal_r;
      REG_SKEW:      prdata = {32'b0, skew_r};
      REG_K1:        prdata = {32'b0, k1_r};
      REG_K2:        prdata = {32'b0, k2_r};
      REG_K3:        prdata = {32'b0, k3_r};
      REG_P1:        prdata = {32'b0, p1_r};
      REG_P2:        prdata = {32'b0, p2_r};
      default:       prdata = '0;
    endcase
  end

  // Q4.28 coefficients widened to Q32.32, Q16.16 camera terms as 64-bit operands
  q32_t k1w, k2w, k3w, p1w, p2w, fxw, fyw, cxw, cyw, skw;
  assign k1w = {{28{k1_r[31]}}, k1_r, 4'b0};
  assign k2w = {{28{k2_r[31]}}, k2_r, 4'b0};
  assign k3w = {{28{k3_r[31]}}, k3_r, 4'b0};
  assign p1w = {{28{p1_r[31]}}, p1_r, 4'b0};
  assign p2w = {{28{p2_r[31]}}, p2_r, 4'b0};
  assign fxw = {32'b0, focal_r[31:0]};
  assign fyw = {32'b0, focal_r[63:32]};
  assign cxw = {32'b0, principal_r[31:0]};
  assign cyw = {32'b0, principal_r[63:32]};
  assign skw = {{32{skew_r[31]}}, skew_r};

  // pipeline advance: the whole pipe moves unless the result is held
  logic en;
  logic [PIPE_LAT-1:0] vld_r;

  assign en        = !vld_r[PIPE_LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  logic behind_in, behind_d;
  assign behind_in = in_camera_z[31] || (in_camera_z == 32'sd0);

  ldp_delay #(.WIDTH(1), .DEPTH(PIPE_LAT - 1)) u_behind_dly (
    .clk(clk), .en(en), .d(behind_in), .q(behind_d)
  );

  // normalized coordinates
  q32_t x_q, y_q;
  ldp_div u_div_x (.clk(clk), .en(en), .num(in_camera_x), .den(in_camera_z[30:0]), .quo(x_q));
  ldp_div u_div_y (.clk(clk), .en(en), .num(in_camera_y), .den(in_camera_z[30:0]), .quo(y_q));

  // squares and radius terms
  q32_t xx, yy, xy;
  ldp_mul u_mul_xx (.clk(clk), .en(en), .a(x_q), .b(x_q), .p(xx));
  ldp_mul u_mul_yy (.clk(clk), .en(en), .a(y_q), .b(y_q), .p(yy));
  ldp_mul u_mul_xy (.clk(clk), .en(en), .a(x_q), .b(y_q), .p(xy));

  q32_t r2_r, xx2_r, yy2_r, xy2_r, tx_r, ty_r;
  always_ff @(posedge clk) begin
    if (en) begin
      r2_r  <= sat_add(xx, yy);
      xx2_r <= sat_add(xx, xx);
      yy2_r <= sat_add(yy, yy);
      xy2_r <= sat_add(xy, xy);
      tx_r  <= sat_add(r2_r, xx2_r);
      ty_r  <= sat_add(r2_r, yy2_r);
    end
  end

  q32_t r4, r6, r2_d;
  ldp_mul u_mul_r4 (.clk(clk), .en(en), .a(r2_r), .b(r2_r), .p(r4));
  ldp_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_r2_dly (
    .clk(clk), .en(en), .d(r2_r), .q(r2_d)
  );
  ldp_mul u_mul_r6 (.clk(clk), .en(en), .a(r4), .b(r2_d), .p(r6));

  // radial factor, summed left to right
  q32_t k1r2, k2r4, k3r6, rad1_r, rad1_d, rad2_r, rad2_d, rad3_r;
  ldp_mul u_mul_k1 (.clk(clk), .en(en), .a(k1w), .b(r2_r), .p(k1r2));
  ldp_mul u_mul_k2 (.clk(clk), .en(en), .a(k2w), .b(r4), .p(k2r4));
  ldp_mul u_mul_k3 (.clk(clk), .en(en), .a(k3w), .b(r6), .p(k3r6));
  ldp_delay #(.WIDTH(64), .DEPTH(MUL_LAT - 1)) u_rad1_dly (
    .clk(clk), .en(en), .d(rad1_r), .q(rad1_d)
  );
  ldp_delay #(.WIDTH(64), .DEPTH(MUL_LAT - 1)) u_rad2_dly (
    .clk(clk), .en(en), .d(rad2_r), .q(rad2_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rad1_r <= sat_add(Q32_ONE, k1r2);
      rad2_r <= sat_add(rad1_d, k2r4);
      rad3_r <= sat_add(rad2_d, k3r6);
    end
  end

  // tangential terms
  q32_t p1xy, p2tx, p1ty, p2xy, p1xy_d, p2xy_d, dx_r, dy_r, dx_d, dy_d;
  ldp_mul u_mul_p1xy (.clk(clk), .en(en), .a(p1w), .b(xy2_r), .p(p1xy));
  ldp_mul u_mul_p2tx (.clk(clk), .en(en), .a(p2w), .b(tx_r), .p(p2tx));
  ldp_mul u_mul_p1ty (.clk(clk), .en(en), .a(p1w), .b(ty_r), .p(p1ty));
  ldp_mul u_mul_p2xy (.clk(clk), .en(en), .a(p2w), .b(xy2_r), .p(p2xy));
  ldp_delay #(.WIDTH(64), .DEPTH(1)) u_p1xy_dly (.clk(clk), .en(en), .d(p1xy), .q(p1xy_d));
  ldp_delay #(.WIDTH(64), .DEPTH(1)) u_p2xy_dly (.clk(clk), .en(en), .d(p2xy), .q(p2xy_d));

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= sat_add(p1xy_d, p2tx);
      dy_r <= sat_add(p1ty, p2xy_d);
    end
  end

  ldp_delay #(.WIDTH(64), .DEPTH(3 * MUL_LAT - 1)) u_dx_dly (
    .clk(clk), .en(en), .d(dx_r), .q(dx_d)
  );
  ldp_delay #(.WIDTH(64), .DEPTH(3 * MUL_LAT - 1)) u_dy_dly (
    .clk(clk), .en(en), .d(dy_r), .q(dy_d)
  );

  // distorted coordinates
  q32_t x_d, y_d, xr, yr, xd_r, yd_r;
  ldp_delay #(.WIDTH(64), .DEPTH(4 * MUL_LAT + 2)) u_x_dly (
    .clk(clk), .en(en), .d(x_q), .q(x_d)
  );
  ldp_delay #(.WIDTH(64), .DEPTH(4 * MUL_LAT + 2)) u_y_dly (
    .clk(clk), .en(en), .d(y_q), .q(y_d)
  );
  ldp_mul u_mul_xr (.clk(clk), .en(en), .a(x_d), .b(rad3_r), .p(xr));
  ldp_mul u_mul_yr (.clk(clk), .en(en), .a(y_d), .b(rad3_r), .p(yr));

  always_ff @(posedge clk) begin
    if (en) begin
      xd_r <= sat_add(xr, dx_d);
      yd_r <= sat_add(yr, dy_d);
    end
  end

  // camera intrinsics
  q32_t pxf, skp, pyf, pyf_d, px2_r, px3_r, py2_r;
  ldp_mul u_mul_fx (.clk(clk), .en(en), .a(fxw), .b(xd_r), .p(pxf));
  ldp_mul u_mul_sk (.clk(clk), .en(en), .a(skw), .b(yd_r), .p(skp));
  ldp_mul u_mul_fy (.clk(clk), .en(en), .a(fyw), .b(yd_r), .p(pyf));
  ldp_delay #(.WIDTH(64), .DEPTH(1)) u_pyf_dly (.clk(clk), .en(en), .d(pyf), .q(pyf_d));

  logic [31:0] pix_x_r, pix_y_r;
  logic        behind_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px2_r <= sat_add(pxf, skp);
      px3_r <= sat_add(px2_r, cxw);
      py2_r <= sat_add(pyf_d, cyw);
      // points at or behind the lens plane report zero pixels
      pix_x_r  <= behind_d ? 32'd0 : sat32(px3_r);
      pix_y_r  <= behind_d ? 32'd0 : sat32(py2_r);
      behind_r <= behind_d;
    end
  end

  assign out_pixel_x       = pix_x_r;
  assign out_pixel_y       = pix_y_r;
  assign out_behind_camera = behind_r;

`ifndef SYNTH
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_behind_camera |-> (out_pixel_x == 32'sd0) && (out_pixel_y == 32'sd0))
    else $error("behind-camera result carries nonzero pixels");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transaction missing from first stage");
`endif

endmodule

>>> verif/tb.sv
// Self-checking testbench for lens_distortion_projection: APB register phases, random
// point traffic with stalls on both sides, and a bit-exact fixed-point projection predictor.
// Depends on ldp_pkg and the lens_distortion_projection RTL.
`timescale 1ns / 100ps

module tb;
  import ldp_pkg::*;

  localparam int PIPE_LAT    = 95;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] pix_x;
    logic signed [31:0] pix_y;
    logic               behind;
  } pixel_t;

  localparam q32_t MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q32_t MIN64 = 64'sh8000_0000_0000_0000;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  logic in_valid, in_ready;
  logic signed [31:0] in_camera_x, in_camera_y, in_camera_z;
  logic out_valid, out_ready;
  logic signed [31:0] out_pixel_x, out_pixel_y;
  logic out_behind_camera;

  // Shadow copy of the block's registers
  logic [63:0] focal_r, principal_r;
  logic [31:0] skew_r, k1_r, k2_r, k3_r, p1_r, p2_r;

  point_t point_q[$];
  pixel_t pixel_q[$];
  int     mismatches;
  int     idle_pct;
  int     cycles;

  lens_distortion_projection dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_camera_x(in_camera_x), .in_camera_y(in_camera_y), .in_camera_z(in_camera_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_x(out_pixel_x), .out_pixel_y(out_pixel_y),
    .out_behind_camera(out_behind_camera)
  );

  function automatic q32_t signed_from_mag(input logic neg, input logic [63:0] mag);
    if (!neg) return mag[63] ? MAX64 : q32_t'(mag);
    return mag[63] ? MIN64 : -q32_t'(mag);
  endfunction

  function automatic logic [63:0] abs64(input q32_t a);
    return a[63] ? 64'd0 - 64'(a) : 64'(a);
  endfunction

  function automatic q32_t add_clamp(input q32_t a, input q32_t b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return MAX64;
    if (s < -65'sh0_8000_0000_0000_0000) return MIN64;
    return s[63:0];
  endfunction

  // Q32.32 product, rounded half away from zero, clamped
  function automatic q32_t mul_round(input q32_t a, input q32_t b);
    logic [127:0] prod;
    prod = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    prod = prod + 128'h8000_0000;
    if (prod[127:96] != 0) return (a[63] ^ b[63]) ? MIN64 : MAX64;
    return signed_from_mag(a[63] ^ b[63], prod[95:32]);
  endfunction

  function automatic q32_t depth_divide(input q32_t num, input q32_t den);
    logic [63:0] mag;
    mag = abs64(num) << 32;
    return signed_from_mag(num[63], mag / 64'(den));
  endfunction

  function automatic logic [31:0] clamp32(input q32_t v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic q32_t coef_q32(input logic [31:0] c);
    return q32_t'($signed(c)) * 16;
  endfunction

  function automatic pixel_t project_point(input point_t pt);
    pixel_t r;
    q32_t x, y, xx, yy, xy, xy2, r2, r4, r6, radial, dx, dy, xd, yd, px, py;
    r = '0;
    if (pt.cam_z <= 0) begin
      r.behind = 1'b1;
      return r;
    end
    x  = depth_divide(q32_t'(pt.cam_x), q32_t'(pt.cam_z));
    y  = depth_divide(q32_t'(pt.cam_y), q32_t'(pt.cam_z));
    xx = mul_round(x, x);
    yy = mul_round(y, y);
    xy = mul_round(x, y);
    r2 = add_clamp(xx, yy);
    r4 = mul_round(r2, r2);
    r6 = mul_round(r4, r2);
    radial = add_clamp(Q32_ONE, mul_round(coef_q32(k1_r), r2));
    radial = add_clamp(radial, mul_round(coef_q32(k2_r), r4));
    radial = add_clamp(radial, mul_round(coef_q32(k3_r), r6));
    xy2 = add_clamp(xy, xy);
    dx = add_clamp(mul_round(coef_q32(p1_r), xy2),
                   mul_round(coef_q32(p2_r), add_clamp(r2, add_clamp(xx, xx))));
    dy = add_clamp(mul_round(coef_q32(p1_r), add_clamp(r2, add_clamp(yy, yy))),
                   mul_round(coef_q32(p2_r), xy2));
    xd = add_clamp(mul_round(x, radial), dx);
    yd = add_clamp(mul_round(y, radial), dy);
    px = mul_round(q32_t'({32'd0, focal_r[31:0]}), xd);
    px = add_clamp(px, mul_round(q32_t'($signed(skew_r)), yd));
    px = add_clamp(px, q32_t'({32'd0, principal_r[31:0]}));
    py = mul_round(q32_t'({32'd0, focal_r[63:32]}), yd);
    py = add_clamp(py, q32_t'({32'd0, principal_r[63:32]}));
    r.pix_x = clamp32(px);
    r.pix_y = clamp32(py);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: predict on acceptance, then present the next point
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        pixel_q.push_back(project_point({in_camera_x, in_camera_y, in_camera_z}));
      if (!in_valid || in_ready) begin
        if (point_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          point_t pt;
          pt = point_q.pop_front();
          in_camera_x <= pt.cam_x;
          in_camera_y <= pt.cam_y;
          in_camera_z <= pt.cam_z;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each pixel transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= idle_pct);
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel transaction x=%h y=%h behind=%b",
                                         out_pixel_x, out_pixel_y, out_behind_camera);
        end else begin
          pixel_t want;
          want = pixel_q.pop_front();
          if (want.pix_x !== out_pixel_x || want.pix_y !== out_pixel_y ||
              want.behind !== out_behind_camera) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected x=%h y=%h behind=%b, got x=%h y=%h behind=%b",
                       want.pix_x, want.pix_y, want.behind,
                       out_pixel_x, out_pixel_y, out_behind_camera);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 6'(idx) << 3; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FOCAL:     focal_r = val;
      REG_PRINCIPAL: principal_r = val;
      REG_SKEW:      skew_r = val[31:0];
      REG_K1:        k1_r = val[31:0];
      REG_K2:        k2_r = val[31:0];
      REG_K3:        k3_r = val[31:0];
      REG_P1:        p1_r = val[31:0];
      default:       p2_r = val[31:0];
    endcase
  endtask

  task automatic load_camera(input logic [63:0] fl, input logic [63:0] pp, input logic [31:0] sk,
                             input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic [31:0] d, input logic [31:0] e);
    reg_write(REG_FOCAL, fl);
    reg_write(REG_PRINCIPAL, pp);
    reg_write(REG_SKEW, {32'd0, sk});
    reg_write(REG_K1, {32'd0, a});
    reg_write(REG_K2, {32'd0, b});
    reg_write(REG_K3, {32'd0, c});
    reg_write(REG_P1, {32'd0, d});
    reg_write(REG_P2, {32'd0, e});
  endtask

  // Small signed coefficient in Q4.28, within about +-0.5
  function automatic logic [31:0] small_coef();
    return 32'($urandom_range(32'h1000_0000)) - 32'h0800_0000;
  endfunction

  task automatic load_typical();
    load_camera({16'($urandom_range(200, 2000)), 16'($urandom), 16'($urandom_range(200, 2000)),
                 16'($urandom)},
                {16'($urandom_range(100, 700)), 16'($urandom), 16'($urandom_range(100, 900)),
                 16'($urandom)},
                32'($urandom_range(32'h2_0000)) - 32'h1_0000,
                small_coef(), small_coef(), small_coef(), small_coef() >>> 4,
                small_coef() >>> 4);
  endtask

  function automatic point_t rand_point();
    point_t pt;
    int sel;
    int unsigned zz;
    sel = $urandom_range(99);
    if (sel < 70) begin
      zz = $urandom_range(32'h0000_4000, 32'h00C8_0000);
      pt.cam_z = zz;
      pt.cam_x = 32'($urandom_range(2 * zz)) - 32'(zz);
      pt.cam_y = 32'($urandom_range(2 * zz)) - 32'(zz);
    end else if (sel < 85) begin
      pt = {32'($urandom), 32'($urandom), 32'($urandom)};
    end else if (sel < 93) begin
      pt.cam_x = $urandom; pt.cam_y = $urandom;
      pt.cam_z = $urandom_range(1, 300);
    end else begin
      pt.cam_x = $urandom; pt.cam_y = $urandom;
      pt.cam_z = -32'($urandom_range(2));
    end
    return pt;
  endfunction

  task automatic drain();
    while (point_q.size() > 0 || in_valid || pixel_q.size() > 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) point_q.push_back(rand_point());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; in_camera_x = '0; in_camera_y = '0; in_camera_z = '0;
    out_ready = 1'b0;
    focal_r = '0; principal_r = '0;
    {skew_r, k1_r, k2_r, k3_r, p1_r, p2_r} = '0;
    mismatches = 0; cycles = 0; idle_pct = 17;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset-value registers: identity-free projection yields principal point of zero
    point_q.push_back({32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000});
    drain();

    load_camera({32'd800 << 16, 32'd640 << 16}, {32'd240 << 16, 32'd320 << 16}, 32'h0000_0100,
                32'hFC00_0000, 32'h0100_0000, 32'hFFF0_0000, 32'h0002_0000, 32'hFFFE_0000);
    point_q.push_back({32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0001});
    point_q.push_back({32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0001});
    point_q.push_back({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    point_q.push_back({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
    point_q.push_back({32'sh0000_0000, 32'sh0000_0000, 32'sh0001_0000});
    point_q.push_back({32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000});
    point_q.push_back({32'sh0001_0000, 32'sh0001_0000, 32'shFFFF_FFFF});
    point_q.push_back({32'sh0001_0000, 32'sh0001_0000, 32'sh8000_0000});
    point_q.push_back({32'sh0000_8000, 32'shFFFF_8000, 32'sh0001_0000});
    point_q.push_back({32'sh0003_0000, 32'shFFFD_0000, 32'sh0001_0000});
    point_q.push_back({32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0001});
    point_q.push_back({32'sh0000_0000, 32'sh0001_0000, 32'sh0002_0000});
    point_q.push_back({32'sh0001_0000, 32'sh0000_0000, 32'sh0002_0000});
    point_q.push_back({32'shFFFF_0000, 32'shFFFF_0000, 32'sh0040_0000});
    point_q.push_back({32'sh0000_0000, 32'sh0000_0000, 32'sh7FFF_FFFF});
    drain();

    load_typical();
    run_random(330);

    // Full-scale registers drive the stages after the divider into saturation
    load_camera(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_random(250);

    load_camera(64'd0, 64'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
    run_random(250);

    load_camera({$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
    run_random(300);

    load_typical();
    run_random(300);

    // Long stretch with no idling on either side
    idle_pct = 0;
    load_typical();
    run_random(500);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/ldp_pkg.sv
hw/rtl/ldp_delay.sv
hw/rtl/ldp_div.sv
hw/rtl/ldp_mul.sv
hw/rtl/lens_distortion_projection.sv
verif/tb.sv
